@@ rtl/mfb_pkg.sv @@
`default_nettype none
package mfb_pkg;

  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 8;
  localparam int POS_W       = 6;
  localparam int FRAME_LEN   = 41;
  localparam int CRC_SPAN    = 39;
  localparam int LAST_POS    = FRAME_LEN - 1;
  localparam int VALUE_FIRST = 15;
  localparam int VALUE_END   = 31;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;
  localparam logic [7:0] REG_ADDR_LO      = 8'h58;
  localparam logic [7:0] REG_COUNT_LO     = 8'h10;
  localparam logic [7:0] BYTE_COUNT       = 8'h20;
  localparam logic [7:0] MODE_ABS         = 8'h01;
  localparam logic [7:0] MODE_REL         = 8'h02;
  localparam logic [7:0] CONST_A_HI       = 8'h03;
  localparam logic [7:0] CONST_A_LO       = 8'hE8;
  localparam logic [7:0] CONST_B_LO       = 8'h01;

  typedef struct packed {
    logic [7:0]       address;
    logic [7:0]       mode_code;
    logic [3:0][31:0] values;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] body_byte(input logic [POS_W-1:0] pos, input cmd_t cmd);
    logic [POS_W-1:0] rel;
    logic [31:0]      v;
    logic [7:0]       b;
    rel = pos - POS_W'(VALUE_FIRST);
    v   = cmd.values[rel[3:2]];
    case (rel[1:0])
      2'd0:    b = v[31:24];
      2'd1:    b = v[23:16];
      2'd2:    b = v[15:8];
      default: b = v[7:0];
    endcase
    case (pos)
      6'd0:    b = cmd.address;
      6'd1:    b = FUNC_WRITE_MULTI;
      6'd3:    b = REG_ADDR_LO;
      6'd5:    b = REG_COUNT_LO;
      6'd6:    b = BYTE_COUNT;
      6'd14:   b = cmd.mode_code;
      6'd33:   b = CONST_A_HI;
      6'd34:   b = CONST_A_LO;
      6'd38:   b = CONST_B_LO;
      default: begin
        if (!(pos >= POS_W'(VALUE_FIRST) && pos < POS_W'(VALUE_END))) begin
          b = 8'h00;
        end
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/mfb_front.sv @@
`default_nettype none
module mfb_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // slave_address[7:0], absolute_mode[8], target_position[40:9], top_speed[72:41],
  // start_slope[104:73], stop_slope[136:105], zero fill[143:137]
  input  wire logic [mfb_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                  push,
  output mfb_pkg::cmd_t                         push_cmd,
  input  wire logic                             queue_full
);

  logic          held_valid;
  mfb_pkg::cmd_t held_cmd;
  mfb_pkg::cmd_t cmd_next;

  assign push     = held_valid && !queue_full;
  assign s_tready = !held_valid || push;
  assign push_cmd = held_cmd;

  always_comb begin
    cmd_next.address   = s_tdata[7:0];
    cmd_next.mode_code = s_tdata[8] ? mfb_pkg::MODE_ABS : mfb_pkg::MODE_REL;
    cmd_next.values[0] = s_tdata[40:9];
    cmd_next.values[1] = s_tdata[72:41];
    cmd_next.values[2] = s_tdata[104:73];
    cmd_next.values[3] = s_tdata[136:105];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_cmd <= cmd_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mfb_queue.sv @@
`default_nettype none
module mfb_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  mfb_pkg::cmd_t      push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output mfb_pkg::cmd_t      head_cmd
);

  mfb_pkg::cmd_t                       entries [mfb_pkg::QUEUE_DEPTH];
  logic [mfb_pkg::QUEUE_PTR_W-1:0]     wr_ptr;
  logic [mfb_pkg::QUEUE_PTR_W-1:0]     rd_ptr;
  logic [mfb_pkg::QUEUE_CNT_W-1:0]     count;
  logic                                do_push;
  logic                                do_pop;

  assign full       = count == mfb_pkg::QUEUE_CNT_W'(mfb_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [mfb_pkg::QUEUE_PTR_W-1:0] bump(
    input logic [mfb_pkg::QUEUE_PTR_W-1:0] p
  );
    if (p == mfb_pkg::QUEUE_PTR_W'(mfb_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mfb_back.sv @@
`default_nettype none
module mfb_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             head_valid,
  input  mfb_pkg::cmd_t                         head_cmd,
  output logic                                  pop,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // frame_byte[7:0]
  output logic [mfb_pkg::OUT_TDATA_W-1:0]       m_tdata,
  output logic                                  m_tlast
);

  logic [mfb_pkg::POS_W-1:0] pos;
  logic [15:0]               crc;
  logic [7:0]                byte_cur;
  logic                      fire;
  logic                      at_last;

  assign fire    = head_valid && (!m_tvalid || m_tready);
  assign at_last = pos == mfb_pkg::POS_W'(mfb_pkg::LAST_POS);
  assign pop     = fire && at_last;

  always_comb begin
    if (pos < mfb_pkg::POS_W'(mfb_pkg::CRC_SPAN)) begin
      byte_cur = mfb_pkg::body_byte(pos, head_cmd);
    end else if (pos == mfb_pkg::POS_W'(mfb_pkg::CRC_SPAN)) begin
      byte_cur = crc[7:0];
    end else begin
      byte_cur = crc[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pos      <= '0;
      crc      <= mfb_pkg::CRC_INIT;
    end else begin
      if (fire) begin
        m_tvalid <= 1'b1;
        if (at_last) begin
          pos <= '0;
          crc <= mfb_pkg::CRC_INIT;
        end else begin
          pos <= pos + 1'b1;
          if (pos < mfb_pkg::POS_W'(mfb_pkg::CRC_SPAN)) begin
            crc <= mfb_pkg::crc_byte(crc, byte_cur);
          end
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= byte_cur;
      m_tlast <= at_last;
    end
  end

endmodule
`default_nettype wire

@@ rtl/modbus_rtu_motor_frame_builder.sv @@
// A command passes through the front-end holding register and a queue entry before
// the back end registers its first frame byte. The back-end byte sequencer sends
// one frame byte per cycle unless m_tready stalls; queued frames follow without gaps.
// A two-entry command queue lets further commands transfer while a frame is sent.
// Reset (rst, synchronous, active high) empties the queue and output register.
`default_nettype none
module modbus_rtu_motor_frame_builder (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // slave_address[7:0], absolute_mode[8], target_position[40:9], top_speed[72:41],
  // start_slope[104:73], stop_slope[136:105], zero fill[143:137]
  input  wire logic [mfb_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // frame_byte[7:0]
  output logic [mfb_pkg::OUT_TDATA_W-1:0]       m_tdata,
  output logic                                  m_tlast
);

  logic          push;
  mfb_pkg::cmd_t push_cmd;
  logic          queue_full;
  logic          pop;
  logic          head_valid;
  mfb_pkg::cmd_t head_cmd;

  mfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  mfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  mfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
`default_nettype wire

@@ dv/mfb_frame_checker.sv @@
`timescale 1ns / 100ps
module mfb_frame_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  input  wire logic [mfb_pkg::IN_TDATA_W-1:0] s_tdata,
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic [mfb_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                           m_tlast,
  output int                                  fail_count,
  output int                                  pending
);
  import mfb_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  frame_beat_t expected_bytes[$];
  int          mismatches = 0;

  assign fail_count = mismatches;
  assign pending    = expected_bytes.size();

  function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  task automatic predict_frame(input logic [IN_TDATA_W-1:0] word);
    logic [7:0]       body[CRC_SPAN];
    logic [3:0][31:0] vals;
    logic [15:0]      crc;
    frame_beat_t      beat;
    vals = word[136:9];
    foreach (body[i]) body[i] = 8'h00;
    body[0]  = word[7:0];
    body[1]  = FUNC_WRITE_MULTI;
    body[3]  = REG_ADDR_LO;
    body[5]  = REG_COUNT_LO;
    body[6]  = BYTE_COUNT;
    body[14] = word[8] ? MODE_ABS : MODE_REL;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        body[VALUE_FIRST + 4 * i + j] = vals[i][31 - 8 * j -: 8];
      end
    end
    body[33] = CONST_A_HI;
    body[34] = CONST_A_LO;
    body[38] = CONST_B_LO;
    crc = CRC_INIT;
    foreach (body[i]) begin
      crc = crc16_modbus_step(crc, body[i]);
      beat.data = body[i];
      beat.last = 1'b0;
      expected_bytes.push_back(beat);
    end
    beat.data = crc[7:0];
    beat.last = 1'b0;
    expected_bytes.push_back(beat);
    beat.data = crc[15:8];
    beat.last = 1'b1;
    expected_bytes.push_back(beat);
  endtask

  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_frame(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual data %h last %b",
                   $time, m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (m_tdata !== want.data) begin
            $display("%0t: frame byte mismatch, expected %h, actual %h",
                     $time, want.data, m_tdata);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: tlast mismatch, expected %b, actual %b",
                     $time, want.last, m_tlast);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

@@ dv/tb_modbus_rtu_motor_frame_builder.sv @@
`timescale 1ns / 100ps
module tb_modbus_rtu_motor_frame_builder;
  import mfb_pkg::*;

  localparam int RANDOM_ITEMS = 410;
  localparam int CYCLE_LIMIT  = 1500000;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   calm     = 1'b0;
  int                     stall_left = 0;
  int                     cycle_count = 0;
  int                     fail_count;
  int                     pending;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  modbus_rtu_motor_frame_builder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  mfb_frame_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 19) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_command(
    input logic [7:0] addr, input logic abs_mode, input logic [31:0] position,
    input logic [31:0] speed, input logic [31:0] start_slope, input logic [31:0] stop_slope,
    input logic [6:0] fill
  );
    return {fill, stop_slope, start_slope, speed, position, abs_mode, addr};
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_command(input logic [IN_TDATA_W-1:0] word);
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_sender(input int cycles);
    s_tvalid <= 1'b0;
    s_tdata  <= IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    logic [7:0] addr;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_command(pack_command(8'h00, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 7'h00));
    send_command(pack_command(8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F));
    send_command(pack_command(8'h01, 1'b1, 32'h1234_5678, 32'd1000, 32'h0000_03E8,
                              32'h1, 7'h00));
    idle_sender(3);
    send_command(pack_command(8'hAA, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555,
                              32'hAAAA_AAAA, 32'h5555_5555, 7'h55));
    send_command(pack_command(8'h55, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA,
                              32'h5555_5555, 32'hAAAA_AAAA, 7'h2A));
    send_command(pack_command(8'h80, 1'b0, 32'h8000_0000, 32'h0000_0001,
                              32'h7FFF_FFFF, 32'hFFFF_FFFE, 7'h7F));
    for (int k = 0; k < 8; k++) begin
      addr = 8'h01 << k;
      send_command(pack_command(addr, k[0], 32'h1 << k, 32'h1 << (k + 8),
                                32'h1 << (k + 16), 32'h1 << (k + 24), 7'h01 << (k % 7)));
      if (k[1]) idle_sender($urandom_range(1, 18));
    end
    send_command(pack_command(8'hFE, 1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFD,
                              32'hFFFF_FFFB, 32'hFFFF_FFF7, 7'h40));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 60) calm <= 1'b1;
      if (!calm && !(i >= 150 && i < 190) && $urandom_range(0, 3) == 0) begin
        idle_sender($urandom_range(1, 18));
      end
      case ($urandom_range(0, 7))
        0:       addr = 8'h00;
        1:       addr = 8'hFF;
        default: addr = 8'($urandom_range(0, 255));
      endcase
      send_command(pack_command(addr, 1'($urandom_range(0, 1)), random_word(),
                                random_word(), random_word(), random_word(),
                                7'($urandom_range(0, 127))));
    end
    s_tvalid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_modbus_rtu_motor_frame_builder OK");
    end else begin
      $display("tb_modbus_rtu_motor_frame_builder NOT OK");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d frame bytes outstanding", cycle_count, pending);
    $display("tb_modbus_rtu_motor_frame_builder NOT OK");
    $finish;
  end

endmodule
